// ===== rtl/core/bmsi_pkg.sv =====
// Shared types and constants for the bank mapper with scanline IRQ.
// Used by bmsi_front, bmsi_fifo, bmsi_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package bmsi_pkg;

	localparam int OP_W    = 3;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int OFS_W   = 21;
	localparam int CNT_W   = 9;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_CPU_RD  = 3'd0;
	localparam logic [OP_W-1:0] OP_CPU_WR  = 3'd1;
	localparam logic [OP_W-1:0] OP_PPU_RD  = 3'd2;
	localparam logic [OP_W-1:0] OP_PPU_WR  = 3'd3;
	localparam logic [OP_W-1:0] OP_SCANLN  = 3'd4;
	localparam logic [OP_W-1:0] OP_IRQ_ACK = 3'd5;

	// result targets
	localparam logic [1:0] TGT_NONE    = 2'd0;
	localparam logic [1:0] TGT_PRG_ROM = 2'd1;
	localparam logic [1:0] TGT_PRG_RAM = 2'd2;
	localparam logic [1:0] TGT_CHR     = 2'd3;

	// mirroring codes
	localparam logic [1:0] MIR_VERT = 2'd0;
	localparam logic [1:0] MIR_FOUR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_MIR  = 2'd3;

	// CPU address map
	localparam logic [ADDR_W-1:0] ADDR_PRG_RAM  = 16'h6000;
	localparam logic [ADDR_W-1:0] ADDR_PRG_ROM  = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_MIRROR   = 16'hA000;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_LAT  = 16'hC000;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_EN   = 16'hE000;

	typedef enum logic [3:0] {
		K_NONE,
		K_PRG_RD,
		K_PRGRAM_RD,
		K_PRGRAM_WR,
		K_REG_WR,
		K_CHR_RD,
		K_CHR_WR,
		K_SCANLINE,
		K_ACK
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmsi_front.sv =====
// Front end: accepts bus transactions and classifies them into commands.
// Depends on bmsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmsi_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [bmsi_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                               push,
	output bmsi_pkg::cmd_t                     push_cmd,
	input  wire logic                          push_ready
);

	logic [bmsi_pkg::OP_W-1:0]   op;
	logic [bmsi_pkg::ADDR_W-1:0] addr;
	logic [bmsi_pkg::DATA_W-1:0] data;
	bmsi_pkg::kind_t             kind;
	logic                        valid_s1;
	bmsi_pkg::cmd_t              cmd_s1;

	assign op   = s_tdata[2:0];
	assign addr = s_tdata[18:3];
	assign data = s_tdata[26:19];

	always_comb begin
		case (op)
			bmsi_pkg::OP_CPU_RD: begin
				if (addr >= bmsi_pkg::ADDR_PRG_ROM) kind = bmsi_pkg::K_PRG_RD;
				else if (addr >= bmsi_pkg::ADDR_PRG_RAM) kind = bmsi_pkg::K_PRGRAM_RD;
				else kind = bmsi_pkg::K_NONE;
			end
			bmsi_pkg::OP_CPU_WR: begin
				if (addr >= bmsi_pkg::ADDR_PRG_ROM) kind = bmsi_pkg::K_REG_WR;
				else if (addr >= bmsi_pkg::ADDR_PRG_RAM) kind = bmsi_pkg::K_PRGRAM_WR;
				else kind = bmsi_pkg::K_NONE;
			end
			bmsi_pkg::OP_PPU_RD:  kind = bmsi_pkg::K_CHR_RD;
			bmsi_pkg::OP_PPU_WR:  kind = bmsi_pkg::K_CHR_WR;
			bmsi_pkg::OP_SCANLN:  kind = bmsi_pkg::K_SCANLINE;
			bmsi_pkg::OP_IRQ_ACK: kind = bmsi_pkg::K_ACK;
			default:              kind = bmsi_pkg::K_NONE;
		endcase
	end

	assign s_tready = !valid_s1 || push_ready;
	assign push     = valid_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.kind <= kind;
			cmd_s1.addr <= addr;
			cmd_s1.data <= data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bmsi_fifo.sv =====
// Short command queue between front and back end.
// Depends on bmsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmsi_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bmsi_pkg::cmd_t push_cmd,
	output logic                push_ready,
	input  wire logic           pop,
	output bmsi_pkg::cmd_t      pop_cmd,
	output logic                pop_valid
);

	localparam logic [bmsi_pkg::QUEUE_AW:0] FULL = (bmsi_pkg::QUEUE_AW + 1)'(bmsi_pkg::QUEUE_DEPTH);

	bmsi_pkg::cmd_t                mem_q [bmsi_pkg::QUEUE_DEPTH];
	logic [bmsi_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [bmsi_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [bmsi_pkg::QUEUE_AW:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// ===== rtl/core/bmsi_back.sv =====
// Back end: mapper registers, IRQ counter, bank mapping with a bit-serial
// bank-count remainder, and the result register. Depends on bmsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmsi_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pop_valid,
	input  wire bmsi_pkg::cmd_t                    pop_cmd,
	output logic                                   pop,
	input  wire logic                              cfg_we,
	input  wire logic [bmsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmsi_pkg::CNT_W-1:0]        cfg_data,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [bmsi_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

	state_t                      state_q;
	// configuration
	logic [bmsi_pkg::CNT_W-1:0]  prg_cnt_q;
	logic [bmsi_pkg::CNT_W-1:0]  chr_cnt_q;
	logic                        chr_ram_q;
	logic [1:0]                  init_mir_q;
	// mapper state
	logic [7:0]                  bank_sel_q;
	logic [7:0]                  bank_q [8];
	logic [1:0]                  mirroring_q;
	logic [7:0]                  irq_reload_q;
	logic [7:0]                  irq_count_q;
	logic                        irq_en_q;
	logic                        irq_flag_q;
	// command in flight
	bmsi_pkg::kind_t             kind_q;
	logic [12:0]                 lo_q;
	logic [7:0]                  data_q;
	logic [7:0]                  dvd_q;
	logic [7:0]                  rem_q;
	logic [8:0]                  dvs_q;
	logic [2:0]                  cnt_q;
	// result register
	logic                        out_valid_q;
	logic [1:0]                  out_tgt_q;
	logic [bmsi_pkg::OFS_W-1:0]  out_ofs_q;
	logic                        out_wr_q;
	logic [7:0]                  out_data_q;
	logic                        out_irq_q;
	logic [1:0]                  out_mir_q;

	logic [8:0]  eff_prg;
	logic [8:0]  eff_chr;
	logic [7:0]  prg_bank;
	logic [7:0]  chr_bank;
	logic [12:0] chr_a;
	logic [8:0]  trial;
	logic [7:0]  rem_next;
	logic [7:0]  scan_count;
	logic        even;
	logic        out_free;
	logic        is_div;
	logic        is_chr;
	logic [1:0]                  res_tgt;
	logic [bmsi_pkg::OFS_W-1:0]  res_ofs;
	logic                        res_wr;
	logic [7:0]                  res_data;

	always_comb begin
		if (prg_cnt_q < 9'd2) eff_prg = 9'd2;
		else if (prg_cnt_q > 9'd256) eff_prg = 9'd256;
		else eff_prg = prg_cnt_q;
		if (chr_cnt_q == 9'd0) eff_chr = 9'd1;
		else if (chr_cnt_q > 9'd256) eff_chr = 9'd256;
		else eff_chr = chr_cnt_q;
	end

	always_comb begin
		case (pop_cmd.addr[14:13])
			2'd0:    prg_bank = bank_sel_q[6] ? 8'(eff_prg - 9'd2) : bank_q[6];
			2'd1:    prg_bank = bank_q[7];
			2'd2:    prg_bank = bank_sel_q[6] ? bank_q[6] : 8'(eff_prg - 9'd2);
			default: prg_bank = 8'(eff_prg - 9'd1);
		endcase
	end

	assign chr_a = pop_cmd.addr[12:0] ^ {bank_sel_q[7], 12'd0};

	always_comb begin
		if (!chr_a[12]) begin
			if (!chr_a[11]) chr_bank = {bank_q[0][7:1], chr_a[10]};
			else chr_bank = {bank_q[1][7:1], chr_a[10]};
		end else begin
			chr_bank = bank_q[{1'b0, chr_a[11:10]} + 3'd2];
		end
	end

	always_comb begin
		res_tgt  = bmsi_pkg::TGT_NONE;
		res_ofs  = '0;
		res_wr   = 1'b0;
		res_data = '0;
		case (kind_q)
			bmsi_pkg::K_PRG_RD: begin
				res_tgt = bmsi_pkg::TGT_PRG_ROM;
				res_ofs = {rem_q, lo_q};
			end
			bmsi_pkg::K_PRGRAM_RD: begin
				res_tgt = bmsi_pkg::TGT_PRG_RAM;
				res_ofs = {8'd0, lo_q};
			end
			bmsi_pkg::K_PRGRAM_WR: begin
				res_tgt  = bmsi_pkg::TGT_PRG_RAM;
				res_ofs  = {8'd0, lo_q};
				res_wr   = 1'b1;
				res_data = data_q;
			end
			bmsi_pkg::K_CHR_RD: begin
				res_tgt = bmsi_pkg::TGT_CHR;
				res_ofs = {3'd0, rem_q, lo_q[9:0]};
			end
			bmsi_pkg::K_CHR_WR: begin
				res_tgt = bmsi_pkg::TGT_CHR;
				res_ofs = {3'd0, rem_q, lo_q[9:0]};
				if (chr_ram_q) begin
					res_wr   = 1'b1;
					res_data = data_q;
				end
			end
			default: ;
		endcase
	end

	assign trial    = {rem_q, dvd_q[7]};
	assign rem_next = (trial >= dvs_q) ? 8'(trial - dvs_q) : trial[7:0];
	assign scan_count = (irq_count_q == 8'd0) ? irq_reload_q : irq_count_q - 8'd1;
	assign even     = !pop_cmd.addr[0];
	assign out_free = !out_valid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && pop_valid;
	assign is_chr   = (pop_cmd.kind == bmsi_pkg::K_CHR_RD) || (pop_cmd.kind == bmsi_pkg::K_CHR_WR);
	assign is_div   = (pop_cmd.kind == bmsi_pkg::K_PRG_RD) || is_chr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prg_cnt_q    <= 9'd2;
			chr_cnt_q    <= 9'd8;
			chr_ram_q    <= 1'b0;
			init_mir_q   <= bmsi_pkg::MIR_VERT;
			bank_sel_q   <= '0;
			for (int i = 0; i < 8; i++) bank_q[i] <= '0;
			mirroring_q  <= bmsi_pkg::MIR_VERT;
			irq_reload_q <= '0;
			irq_count_q  <= '0;
			irq_en_q     <= 1'b0;
			irq_flag_q   <= 1'b0;
			kind_q       <= bmsi_pkg::K_NONE;
			lo_q         <= '0;
			data_q       <= '0;
			dvd_q        <= '0;
			rem_q        <= '0;
			dvs_q        <= 9'd1;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_tgt_q    <= bmsi_pkg::TGT_NONE;
			out_ofs_q    <= '0;
			out_wr_q     <= 1'b0;
			out_data_q   <= '0;
			out_irq_q    <= 1'b0;
			out_mir_q    <= bmsi_pkg::MIR_VERT;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_OUT) out_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					bmsi_pkg::CFG_PRG_COUNT: prg_cnt_q <= cfg_data;
					bmsi_pkg::CFG_CHR_COUNT: chr_cnt_q <= cfg_data;
					bmsi_pkg::CFG_CHR_RAM:   chr_ram_q <= cfg_data[0];
					bmsi_pkg::CFG_INIT_MIR: begin
						init_mir_q  <= cfg_data[1:0];
						mirroring_q <= cfg_data[1] ? bmsi_pkg::MIR_FOUR : cfg_data[1:0];
					end
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						kind_q <= pop_cmd.kind;
						lo_q   <= is_chr ? chr_a : pop_cmd.addr[12:0];
						data_q <= pop_cmd.data;
						rem_q  <= '0;
						cnt_q  <= '0;
						if (pop_cmd.kind == bmsi_pkg::K_PRG_RD) begin
							dvd_q <= prg_bank;
							dvs_q <= eff_prg;
						end else begin
							dvd_q <= chr_bank;
							dvs_q <= eff_chr;
						end
						case (pop_cmd.kind)
							bmsi_pkg::K_REG_WR: begin
								if (pop_cmd.addr < bmsi_pkg::ADDR_MIRROR) begin
									if (even) bank_sel_q <= pop_cmd.data;
									else bank_q[bank_sel_q[2:0]] <= pop_cmd.data;
								end else if (pop_cmd.addr < bmsi_pkg::ADDR_IRQ_LAT) begin
									if (even && !init_mir_q[1]) mirroring_q <= {1'b0, pop_cmd.data[0]};
								end else if (pop_cmd.addr < bmsi_pkg::ADDR_IRQ_EN) begin
									if (even) irq_reload_q <= pop_cmd.data;
									else irq_count_q <= '0;
								end else begin
									if (even) begin
										irq_en_q   <= 1'b0;
										irq_flag_q <= 1'b0;
									end else begin
										irq_en_q <= 1'b1;
									end
								end
							end
							bmsi_pkg::K_SCANLINE: begin
								irq_count_q <= scan_count;
								if (scan_count == 8'd0 && irq_en_q) irq_flag_q <= 1'b1;
							end
							bmsi_pkg::K_ACK: irq_flag_q <= 1'b0;
							default: ;
						endcase
						state_q <= is_div ? ST_DIV : ST_OUT;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					dvd_q <= {dvd_q[6:0], 1'b0};
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_irq_q   <= irq_flag_q;
						out_mir_q   <= mirroring_q;
						out_tgt_q   <= res_tgt;
						out_ofs_q   <= res_ofs;
						out_wr_q    <= res_wr;
						out_data_q  <= res_data;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_mir_q, out_irq_q, out_data_q, out_wr_q, out_ofs_q, out_tgt_q};

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tgt_q == bmsi_pkg::TGT_NONE |-> out_ofs_q == '0 && !out_wr_q)
		else $error("empty result carries offset or write");

	a_rem_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> {1'b0, rem_q} < dvs_q)
		else $error("partial remainder not below bank count");

	a_four_screen_lock: assert property (@(posedge clk) disable iff (!arst_n)
		init_mir_q[1] |-> mirroring_q == bmsi_pkg::MIR_FOUR)
		else $error("four-screen mirroring not held");

	a_div_leads_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == 3'd7 |=> state_q == ST_OUT)
		else $error("remainder did not finish in eight steps");

endmodule
`default_nettype wire

// ===== rtl/core/bank_mapper_with_scanline_irq.sv =====
// ROM and character accesses pass the front register, the queue, the eight-step
// bank-count remainder and the result register; other kinds skip the remainder.
// The back end works one command at a time: it takes the next command from
// the queue only after the previous result is registered.
// Reset (arst_n low) clears all mapper state and loads register defaults.
// Top level: joins front end, command queue and back end. Depends on bmsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bank_mapper_with_scanline_irq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// operation[2:0], address[18:3], write_data[26:19], zero fill
	input  wire logic [bmsi_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// target[1:0], mem_offset[22:2], mem_write[23], mem_data[31:24],
	// irq_line[32], mirror_mode[34:33], zero fill
	output logic [bmsi_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [bmsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmsi_pkg::CNT_W-1:0]        cfg_data
);

	logic           push;
	logic           push_ready;
	bmsi_pkg::cmd_t push_cmd;
	logic           pop;
	logic           pop_valid;
	bmsi_pkg::cmd_t pop_cmd;

	bmsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	bmsi_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_cmd    (pop_cmd),
		.pop_valid  (pop_valid)
	);

	bmsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire
